// ===== rtl/core/cbm_pkg.sv =====
package cbm_pkg;

  localparam int ROM_DEPTH  = 262144;
  localparam int ROM_AW     = $clog2(ROM_DEPTH);
  localparam int MAX_BANKS  = ROM_DEPTH / 16384;
  localparam int WRAM_DEPTH = 2048;
  localparam int CRAM_DEPTH = 8192;
  localparam int WRAM_AW    = $clog2(WRAM_DEPTH);
  localparam int CRAM_AW    = $clog2(CRAM_DEPTH);

  localparam logic [18:0] ROM_LIMIT = 19'(ROM_DEPTH);

  // Mapper kinds; any other code behaves as fixed
  localparam logic [1:0] MAP_FIXED = 2'd0;
  localparam logic [1:0] MAP_UXROM = 2'd1;
  localparam logic [1:0] MAP_AXROM = 2'd2;

  localparam logic [1:0] MIR_HORIZ     = 2'd0;
  localparam logic [1:0] MIR_VERT      = 2'd1;
  localparam logic [1:0] MIR_SINGLE_LO = 2'd2;
  localparam logic [1:0] MIR_SINGLE_HI = 2'd3;

  localparam logic [1:0] CFG_MAPPER_KIND = 2'd0;
  localparam logic [1:0] CFG_ROM_BANKS   = 2'd1;
  localparam logic [1:0] CFG_HEADER_VERT = 2'd2;

  localparam logic [15:0] WRAM_END        = 16'h2000;
  localparam logic [15:0] PPU_END         = 16'h4000;
  localparam logic [15:0] APU_LAST        = 16'h4013;
  localparam logic [15:0] ADDR_DMA        = 16'h4014;
  localparam logic [15:0] ADDR_APU_STATUS = 16'h4015;
  localparam logic [15:0] ADDR_PAD0       = 16'h4016;
  localparam logic [15:0] ADDR_PAD1       = 16'h4017;
  localparam logic [15:0] OPEN_END        = 16'h6000;
  localparam logic [15:0] CRAM_END        = 16'h8000;
  localparam logic [7:0]  PAD_OPEN_BUS    = 8'h40;

  typedef enum logic [1:0] {
    OP_READ,
    OP_WRITE,
    OP_LOAD,
    OP_BUTTONS
  } op_t;

  typedef enum logic [2:0] {
    TGT_INTERNAL,
    TGT_PPU,
    TGT_APU,
    TGT_DMA,
    TGT_IGNORED
  } target_t;

  typedef enum logic [2:0] {
    SRC_IMM,
    SRC_WRAM,
    SRC_CRAM,
    SRC_ROM,
    SRC_OPEN
  } src_t;

  typedef struct packed {
    logic               wram_we;
    logic               wram_re;
    logic [WRAM_AW-1:0] wram_addr;
    logic               cram_we;
    logic               cram_re;
    logic [CRAM_AW-1:0] cram_addr;
    logic               rom_we;
    logic [ROM_AW-1:0]  rom_waddr;
    logic               rom_re;
    logic [ROM_AW-1:0]  rom_raddr;
    logic [7:0]         wdata;
  } mem_req_t;

  typedef struct packed {
    src_t       src;
    logic [7:0] imm;
    logic [7:0] wdata;
    target_t    target;
    logic [4:0] reg_index;
    logic [7:0] fwd;
    logic [1:0] mirror;
    logic       is_read;
    logic       is_write;
  } item_t;

  // Byte mask of the effective ROM: size clamped, then rounded down to a power of two
  function automatic logic [ROM_AW-1:0] rom_len_mask(logic [4:0] banks16);
    logic [5:0]  b;
    logic [5:0]  p;
    logic [19:0] m;
    b = {1'b0, banks16};
    if (b == 6'd0) b = 6'd1;
    if (b > 6'(MAX_BANKS)) b = 6'(MAX_BANKS);
    p = 6'd1;
    for (int i = 1; i < 6; i++) begin
      if (b[i]) p = 6'd1 << i;
    end
    m = {p, 14'd0} - 20'd1;
    return m[ROM_AW-1:0];
  endfunction

endpackage

// ===== rtl/core/cbm_ram.sv =====
module cbm_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/cbm_decode.sv =====
module cbm_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [1:0]          op,
  input  logic [15:0]         addr,
  input  logic [7:0]          data,
  input  logic [7:0]          ext_data,
  input  logic                pad_port,
  input  logic [17:0]         rom_offset,
  input  logic [1:0]          mapper_kind,
  input  logic [4:0]          rom_banks_16k,
  input  logic                header_vertical,
  output cbm_pkg::mem_req_t   req,
  output cbm_pkg::item_t      item
);

  logic [7:0]      bank_select, bank_select_next;
  logic [1:0]      mirror_state, mirror_state_next;
  logic            strobe, strobe_next;
  logic [1:0][7:0] live, live_next;
  logic [1:0][7:0] latched, latched_next;
  logic [1:0][3:0] shift, shift_next;

  logic [cbm_pkg::ROM_AW-1:0] len_mask;
  logic [22:0]                rom_wide;
  logic                       p;
  logic                       pad_bit;

  assign len_mask = cbm_pkg::rom_len_mask(rom_banks_16k);

  always_comb begin
    unique case (mapper_kind)
      cbm_pkg::MAP_UXROM: rom_wide = {1'b0, (addr[14] ? 8'hff : bank_select), addr[13:0]};
      cbm_pkg::MAP_AXROM: rom_wide = {bank_select, addr[14:0]};
      default:            rom_wide = {8'd0, addr[14:0]};
    endcase
  end

  always_comb begin
    bank_select_next  = bank_select;
    mirror_state_next = mirror_state;
    strobe_next       = strobe;
    live_next         = live;
    latched_next      = latched;
    shift_next        = shift;
    p                 = addr[0];
    pad_bit           = 1'b1;

    req           = '0;
    req.wram_addr = addr[cbm_pkg::WRAM_AW-1:0];
    req.cram_addr = addr[cbm_pkg::CRAM_AW-1:0];
    req.rom_waddr = rom_offset[cbm_pkg::ROM_AW-1:0];
    req.rom_raddr = rom_wide[cbm_pkg::ROM_AW-1:0] & len_mask;
    req.wdata     = data;

    item           = '0;
    item.src       = cbm_pkg::SRC_IMM;
    item.target    = cbm_pkg::TGT_INTERNAL;
    item.wdata     = data;

    unique case (cbm_pkg::op_t'(op))
      cbm_pkg::OP_READ: begin
        item.is_read = 1'b1;
        priority if (addr < cbm_pkg::WRAM_END) begin
          item.src    = cbm_pkg::SRC_WRAM;
          req.wram_re = 1'b1;
        end else if (addr < cbm_pkg::PPU_END) begin
          item.imm       = ext_data;
          item.target    = cbm_pkg::TGT_PPU;
          item.reg_index = {2'b00, addr[2:0]};
        end else if (addr == cbm_pkg::ADDR_APU_STATUS) begin
          item.imm       = ext_data;
          item.target    = cbm_pkg::TGT_APU;
          item.reg_index = addr[4:0];
        end else if (addr == cbm_pkg::ADDR_PAD0 || addr == cbm_pkg::ADDR_PAD1) begin
          // Strobe high reads live bit 0; otherwise shift out, then ones
          priority if (strobe) begin
            pad_bit = live[p][0];
          end else if (!shift[p][3]) begin
            pad_bit       = latched[p][shift[p][2:0]];
            shift_next[p] = shift[p] + 4'd1;
          end else begin
            pad_bit = 1'b1;
          end
          item.imm = cbm_pkg::PAD_OPEN_BUS | {7'd0, pad_bit};
        end else if (addr < cbm_pkg::OPEN_END) begin
          item.src = cbm_pkg::SRC_OPEN;
        end else if (addr < cbm_pkg::CRAM_END) begin
          item.src    = cbm_pkg::SRC_CRAM;
          req.cram_re = 1'b1;
        end else begin
          item.src   = cbm_pkg::SRC_ROM;
          req.rom_re = 1'b1;
        end
      end
      cbm_pkg::OP_WRITE: begin
        item.is_write = 1'b1;
        priority if (addr < cbm_pkg::WRAM_END) begin
          req.wram_we = 1'b1;
        end else if (addr < cbm_pkg::PPU_END) begin
          item.target    = cbm_pkg::TGT_PPU;
          item.reg_index = {2'b00, addr[2:0]};
          item.fwd       = data;
        end else if (addr == cbm_pkg::ADDR_DMA) begin
          item.target = cbm_pkg::TGT_DMA;
          item.fwd    = data;
        end else if (addr == cbm_pkg::ADDR_PAD0) begin
          strobe_next = data[0];
          if (data[0] || strobe) begin
            latched_next = live;
            shift_next   = '0;
          end
        end else if (addr <= cbm_pkg::APU_LAST || addr == cbm_pkg::ADDR_APU_STATUS ||
                     addr == cbm_pkg::ADDR_PAD1) begin
          item.target    = cbm_pkg::TGT_APU;
          item.reg_index = addr[4:0];
          item.fwd       = data;
        end else if (addr < cbm_pkg::OPEN_END) begin
          item.target = cbm_pkg::TGT_IGNORED;
        end else if (addr < cbm_pkg::CRAM_END) begin
          req.cram_we = 1'b1;
        end else begin
          unique case (mapper_kind)
            cbm_pkg::MAP_UXROM: bank_select_next = data;
            cbm_pkg::MAP_AXROM: begin
              bank_select_next  = {5'd0, data[2:0]};
              mirror_state_next = data[4] ? cbm_pkg::MIR_SINGLE_HI : cbm_pkg::MIR_SINGLE_LO;
            end
            default: item.target = cbm_pkg::TGT_IGNORED;
          endcase
        end
      end
      cbm_pkg::OP_LOAD: begin
        req.rom_we = ({1'b0, rom_offset} < cbm_pkg::ROM_LIMIT);
      end
      cbm_pkg::OP_BUTTONS: begin
        live_next[pad_port] = data;
      end
    endcase

    item.mirror = (mapper_kind == cbm_pkg::MAP_AXROM) ? mirror_state_next
                                                      : {1'b0, header_vertical};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_select  <= '0;
      mirror_state <= cbm_pkg::MIR_SINGLE_LO;
      strobe       <= 1'b0;
      live         <= '0;
      latched      <= '0;
      shift        <= '0;
    end else if (accept) begin
      bank_select  <= bank_select_next;
      mirror_state <= mirror_state_next;
      strobe       <= strobe_next;
      live         <= live_next;
      latched      <= latched_next;
      shift        <= shift_next;
    end
  end

endmodule

// ===== rtl/core/cpu_bus_decoder_bank_mapper.sv =====
// Pipeline: a result passes through the registered RAM read (the read stage), then
// the output register.
// Throughput: one item per cycle unless the output stalls or RAM is being cleared.
// A stalled output holds one result and one more item in the read stage before in_ready drops.
// Reset: synchronous; after it a clearing pass zeroes work and cartridge RAM, with in_ready low.
// Configuration writes are taken throughout. Program ROM is not cleared.
module cpu_bus_decoder_bank_mapper (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [15:0] addr,
  input  logic [7:0]  data,
  input  logic [7:0]  ext_data,
  input  logic        pad_port,
  input  logic [17:0] rom_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic [2:0]  target,
  output logic [4:0]  reg_index,
  output logic [7:0]  fwd_data,
  output logic [1:0]  mirror_mode,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  logic [1:0] mapper_kind;
  logic [4:0] rom_banks_16k;
  logic       header_vertical;

  logic                        clearing;
  logic [cbm_pkg::CRAM_AW-1:0] clr_addr;

  logic             accept;
  logic             s1_valid;
  logic             s1_move;
  cbm_pkg::item_t   s1;
  cbm_pkg::item_t   item;
  cbm_pkg::mem_req_t req;
  logic [7:0]       last_bus_value;
  logic [7:0]       rd;
  logic [7:0]       wram_q, cram_q, rom_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mapper_kind     <= cbm_pkg::MAP_FIXED;
      rom_banks_16k   <= 5'd2;
      header_vertical <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cbm_pkg::CFG_MAPPER_KIND: mapper_kind     <= cfg_data[1:0];
        cbm_pkg::CFG_ROM_BANKS:   rom_banks_16k   <= cfg_data;
        cbm_pkg::CFG_HEADER_VERT: header_vertical <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sweep both RAMs once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (&clr_addr) clearing <= 1'b0;
    end
  end

  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !clearing && (!s1_valid || s1_move);
  assign accept   = in_valid && in_ready;

  cbm_decode u_decode (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .op              (op),
    .addr            (addr),
    .data            (data),
    .ext_data        (ext_data),
    .pad_port        (pad_port),
    .rom_offset      (rom_offset),
    .mapper_kind     (mapper_kind),
    .rom_banks_16k   (rom_banks_16k),
    .header_vertical (header_vertical),
    .req             (req),
    .item            (item)
  );

  cbm_ram #(.DEPTH(cbm_pkg::WRAM_DEPTH), .WIDTH(8)) u_wram (
    .clk   (clk),
    .we    (clearing || (accept && req.wram_we)),
    .waddr (clearing ? clr_addr[cbm_pkg::WRAM_AW-1:0] : req.wram_addr),
    .wdata (clearing ? 8'd0 : req.wdata),
    .re    (accept && req.wram_re),
    .raddr (req.wram_addr),
    .rdata (wram_q)
  );

  cbm_ram #(.DEPTH(cbm_pkg::CRAM_DEPTH), .WIDTH(8)) u_cram (
    .clk   (clk),
    .we    (clearing || (accept && req.cram_we)),
    .waddr (clearing ? clr_addr : req.cram_addr),
    .wdata (clearing ? 8'd0 : req.wdata),
    .re    (accept && req.cram_re),
    .raddr (req.cram_addr),
    .rdata (cram_q)
  );

  cbm_ram #(.DEPTH(cbm_pkg::ROM_DEPTH), .WIDTH(8)) u_rom (
    .clk   (clk),
    .we    (accept && req.rom_we),
    .waddr (req.rom_waddr),
    .wdata (req.wdata),
    .re    (accept && req.rom_re),
    .raddr (req.rom_raddr),
    .rdata (rom_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1 <= item;
  end

  // Open bus resolves here, after every earlier read and write has updated it
  always_comb begin
    unique case (s1.src)
      cbm_pkg::SRC_IMM:  rd = s1.imm;
      cbm_pkg::SRC_WRAM: rd = wram_q;
      cbm_pkg::SRC_CRAM: rd = cram_q;
      cbm_pkg::SRC_ROM:  rd = rom_q;
      cbm_pkg::SRC_OPEN: rd = last_bus_value;
      default:           rd = s1.imm;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      last_bus_value <= '0;
    end else begin
      if (s1_move) begin
        out_valid <= 1'b1;
        if (s1.is_read) last_bus_value <= rd;
        else if (s1.is_write) last_bus_value <= s1.wdata;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      read_data   <= rd;
      target      <= s1.target;
      reg_index   <= s1.reg_index;
      fwd_data    <= s1.fwd;
      mirror_mode <= s1.mirror;
    end
  end

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("input taken during RAM clearing pass");

  a_read_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |=> (s1_valid && $stable(s1)))
    else $error("read stage lost its item while output stalled");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken with pipeline full");

  a_reg_index_fwd_only: assert property (@(posedge clk) disable iff (rst)
    (out_valid && reg_index != 5'd0) |->
      (target == cbm_pkg::TGT_PPU || target == cbm_pkg::TGT_APU))
    else $error("register index on a non-forwarded result");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import cbm_pkg::*;

  localparam int          RUN_LIMIT       = 300000;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          ITEMS_PER_PHASE = 125;
  localparam int          PHASES          = 8;
  localparam logic [1:0]  MAP_SPARE       = 2'd3;
  localparam logic [15:0] ROM_BASE        = CRAM_END;
  localparam logic [15:0] CRAM_BASE       = OPEN_END;

  typedef struct packed {
    op_t         op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [7:0]  ext;
    logic        pad_port;
    logic [17:0] rom_offset;
  } bus_access_t;

  typedef struct packed {
    logic [7:0] read_data;
    target_t    tgt;
    logic [4:0] reg_index;
    logic [7:0] fwd;
    logic [1:0] mirror;
  } bus_reply_t;

  class bus_decode_tracker;
    logic [7:0] work_mem [WRAM_DEPTH];
    logic [7:0] cart_mem [CRAM_DEPTH];
    logic [7:0] rom_mem [ROM_DEPTH];
    bit         rom_loaded [ROM_DEPTH];
    logic [7:0] bank_sel;
    logic [1:0] screen;
    logic [7:0] bus_latch;
    logic       strobe;
    logic [7:0] pad_live [2];
    logic [7:0] pad_shift [2];
    logic [3:0] pad_count [2];
    logic [1:0] kind;
    logic [4:0] banks;
    logic       vert;
    bus_reply_t replies_due [$];
    int         mismatches;
    int         matched;
    int         op_seen [4];

    function new();
      foreach (work_mem[i]) work_mem[i] = '0;
      foreach (cart_mem[i]) cart_mem[i] = '0;
      foreach (pad_live[i]) begin
        pad_live[i] = '0;
        pad_shift[i] = '0;
        pad_count[i] = '0;
      end
      foreach (op_seen[i]) op_seen[i] = 0;
      bank_sel = '0;
      screen = MIR_SINGLE_LO;
      bus_latch = '0;
      strobe = 1'b0;
      kind = MAP_FIXED;
      banks = 5'd2;
      vert = 1'b0;
      mismatches = 0;
      matched = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [4:0] val);
      case (idx)
        CFG_MAPPER_KIND: kind = val[1:0];
        CFG_ROM_BANKS:   banks = val;
        CFG_HEADER_VERT: vert = val[0];
        default: ;
      endcase
    endfunction

    // ROM size in 16 KB banks after clamping and rounding down to a power of two
    function int unsigned live_banks();
      int unsigned b, p;
      b = banks;
      if (b < 1) b = 1;
      if (b > MAX_BANKS) b = MAX_BANKS;
      p = 1;
      while (p * 2 <= b) p = p * 2;
      return p;
    endfunction

    function logic [17:0] rom_index(logic [15:0] a);
      int unsigned nb, span, sel;
      nb = live_banks();
      span = nb << 14;
      if (kind == MAP_AXROM) begin
        sel = (nb >> 1) != 0 ? (nb >> 1) - 1 : 0;
        return 18'((((bank_sel & sel) << 15) | (a & 16'h7fff)) & (span - 1));
      end else if (kind == MAP_UXROM) begin
        sel = (a < 16'hc000) ? (bank_sel & (nb - 1)) : nb - 1;
        return 18'((sel << 14) | (a & 16'h3fff));
      end
      return 18'((a - ROM_BASE) & (span - 1));
    endfunction

    function logic [7:0] pad_read(int p);
      logic b;
      if (strobe) begin
        b = pad_live[p][0];
      end else if (pad_count[p] < 8) begin
        b = pad_shift[p][pad_count[p]];
        pad_count[p]++;
      end else begin
        b = 1'b1;
      end
      return PAD_OPEN_BUS | {7'b0, b};
    endfunction

    function void take_access(bus_access_t a);
      bus_reply_t r;
      logic       was;
      r = '0;
      r.tgt = TGT_INTERNAL;
      op_seen[a.op]++;
      case (a.op)
        OP_READ: begin
          if (a.addr < WRAM_END) begin
            r.read_data = work_mem[a.addr[10:0]];
          end else if (a.addr < PPU_END) begin
            r.read_data = a.ext;
            r.tgt = TGT_PPU;
            r.reg_index = {2'b0, a.addr[2:0]};
          end else if (a.addr == ADDR_APU_STATUS) begin
            r.read_data = a.ext;
            r.tgt = TGT_APU;
            r.reg_index = a.addr[4:0];
          end else if (a.addr == ADDR_PAD0) begin
            r.read_data = pad_read(0);
          end else if (a.addr == ADDR_PAD1) begin
            r.read_data = pad_read(1);
          end else if (a.addr < OPEN_END) begin
            r.read_data = bus_latch;
          end else if (a.addr < CRAM_END) begin
            r.read_data = cart_mem[a.addr[12:0]];
          end else begin
            r.read_data = rom_mem[rom_index(a.addr)];
          end
          bus_latch = r.read_data;
        end
        OP_WRITE: begin
          bus_latch = a.data;
          if (a.addr < WRAM_END) begin
            work_mem[a.addr[10:0]] = a.data;
          end else if (a.addr < PPU_END) begin
            r.tgt = TGT_PPU;
            r.reg_index = {2'b0, a.addr[2:0]};
            r.fwd = a.data;
          end else if (a.addr == ADDR_DMA) begin
            r.tgt = TGT_DMA;
            r.fwd = a.data;
          end else if (a.addr == ADDR_PAD0) begin
            was = strobe;
            strobe = a.data[0];
            // latch on either edge of the strobe, and while it is held high
            if (strobe || was) begin
              pad_shift[0] = pad_live[0];
              pad_shift[1] = pad_live[1];
              pad_count[0] = '0;
              pad_count[1] = '0;
            end
          end else if (a.addr <= APU_LAST || a.addr == ADDR_APU_STATUS ||
                       a.addr == ADDR_PAD1) begin
            r.tgt = TGT_APU;
            r.reg_index = a.addr[4:0];
            r.fwd = a.data;
          end else if (a.addr < OPEN_END) begin
            r.tgt = TGT_IGNORED;
          end else if (a.addr < CRAM_END) begin
            cart_mem[a.addr[12:0]] = a.data;
          end else if (kind == MAP_UXROM) begin
            bank_sel = a.data;
          end else if (kind == MAP_AXROM) begin
            bank_sel = {5'b0, a.data[2:0]};
            screen = a.data[4] ? MIR_SINGLE_HI : MIR_SINGLE_LO;
          end else begin
            r.tgt = TGT_IGNORED;
          end
        end
        OP_LOAD: begin
          if (a.rom_offset < ROM_DEPTH) begin
            rom_mem[a.rom_offset] = a.data;
            rom_loaded[a.rom_offset] = 1'b1;
          end
        end
        default: pad_live[a.pad_port] = a.data;
      endcase
      r.mirror = (kind == MAP_AXROM) ? screen : (vert ? MIR_VERT : MIR_HORIZ);
      replies_due.push_back(r);
    endfunction

    function void check_response(bus_reply_t got);
      bus_reply_t want;
      if (replies_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: read_data %h target %0d reg %h fwd %h mirror %0d",
                   got.read_data, got.tgt, got.reg_index, got.fwd, got.mirror);
        mismatches++;
        return;
      end
      want = replies_due.pop_front();
      if (got.read_data !== want.read_data || got.tgt !== want.tgt ||
          got.reg_index !== want.reg_index || got.fwd !== want.fwd ||
          got.mirror !== want.mirror) begin
        if (mismatches < 10)
          $display({"result mismatch (expected/actual): read_data %h/%h target %0d/%0d ",
                    "reg %h/%h fwd %h/%h mirror %0d/%0d"},
                   want.read_data, got.read_data, want.tgt, got.tgt,
                   want.reg_index, got.reg_index, want.fwd, got.fwd,
                   want.mirror, got.mirror);
        mismatches++;
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  op;
  logic [15:0] addr;
  logic [7:0]  data;
  logic [7:0]  ext_data;
  logic        pad_port;
  logic [17:0] rom_offset;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  read_data;
  logic [2:0]  target;
  logic [4:0]  reg_index;
  logic [7:0]  fwd_data;
  logic [1:0]  mirror_mode;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [4:0]  cfg_data;

  bus_decode_tracker tracker;
  bit                calm = 1'b0;
  int                out_hold = 0;
  int unsigned       tick_total = 0;

  logic [1:0] plan_kind [PHASES] = '{MAP_UXROM, MAP_AXROM, MAP_AXROM, MAP_UXROM,
                                     MAP_SPARE, MAP_FIXED, MAP_AXROM, MAP_UXROM};
  logic [4:0] plan_banks [PHASES] = '{5'd16, 5'd16, 5'd1, 5'd0, 5'd31, 5'd1, 5'd4, 5'd2};
  logic       plan_vert [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

  cpu_bus_decoder_bank_mapper uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .addr        (addr),
    .data        (data),
    .ext_data    (ext_data),
    .pad_port    (pad_port),
    .rom_offset  (rom_offset),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_data   (read_data),
    .target      (target),
    .reg_index   (reg_index),
    .fwd_data    (fwd_data),
    .mirror_mode (mirror_mode),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    tick_total <= tick_total + 1;
    if (tick_total == RUN_LIMIT) begin
      $display("run stopped after %0d cycles without finishing", tick_total);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_response(bus_reply_t'{read_data, target_t'(target), reg_index,
                                          fwd_data, mirror_mode});
  end

  // Result side: random back-pressure (none while calm), plus a long hold-off when one is requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_hold > 0) begin
        out_ready <= 1'b0;
        out_hold--;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 33);
      end
    end
  end

  function automatic bus_access_t form(op_t o, logic [15:0] a, logic [7:0] d,
                                       logic p = 1'b0, logic [17:0] off = '0);
    bus_access_t x;
    x.op = o;
    x.addr = a;
    x.data = d;
    x.ext = 8'($urandom);
    x.pad_port = p;
    x.rom_offset = off;
    return x;
  endfunction

  // Called and returns at a falling edge
  task automatic push_access(input bus_access_t a);
    int gap;
    gap = 0;
    if (!calm)
      while (gap < 16 && $urandom_range(99) < 33) gap++;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= a.op;
    addr <= a.addr;
    data <= a.data;
    ext_data <= a.ext;
    pad_port <= a.pad_port;
    rom_offset <= a.rom_offset;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_access(a);
    @(negedge clk);
  endtask

  // Load the ROM byte behind a read first, so no read ever lands on an unloaded byte
  task automatic issue(input bus_access_t a);
    logic [17:0] idx;
    if (a.op == OP_READ && a.addr >= ROM_BASE) begin
      idx = tracker.rom_index(a.addr);
      if (!tracker.rom_loaded[idx])
        push_access(form(OP_LOAD, 16'($urandom), 8'($urandom), 1'($urandom), idx));
    end
    push_access(a);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [4:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic set_mapping(input logic [1:0] kind, input logic [4:0] banks,
                             input logic vert);
    write_cfg(CFG_MAPPER_KIND, {3'b0, kind});
    write_cfg(CFG_ROM_BANKS, banks);
    write_cfg(CFG_HEADER_VERT, {4'b0, vert});
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.replies_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_phase(input int count);
    int          n, pick, k;
    logic [15:0] a;
    logic        port;
    bus_access_t x;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        // controller poll: set buttons, strobe high then low, shift the bits out
        port = 1'($urandom);
        issue(form(OP_BUTTONS, 16'($urandom), 8'($urandom), port));
        issue(form(OP_WRITE, ADDR_PAD0, 8'($urandom) | 8'h01));
        issue(form(OP_WRITE, ADDR_PAD0, 8'($urandom) & 8'hfe));
        k = $urandom_range(6, 11);
        repeat (k) begin
          if ($urandom_range(3) == 0) port = ~port;
          issue(form(OP_READ, port ? ADDR_PAD1 : ADDR_PAD0, 8'($urandom)));
        end
        n += 3 + k;
      end else if (pick < 25) begin
        a = 16'($urandom_range(WRAM_END - 1));
        issue(form(OP_WRITE, a, 8'($urandom)));
        issue(form(OP_READ, {3'b000, 2'($urandom), a[10:0]}, 8'($urandom)));
        n += 2;
      end else if (pick < 35) begin
        a = CRAM_BASE + 16'($urandom_range(CRAM_DEPTH - 1));
        issue(form(OP_WRITE, a, 8'($urandom)));
        if ($urandom_range(1) == 0) a = CRAM_BASE + 16'($urandom_range(CRAM_DEPTH - 1));
        issue(form(OP_READ, a, 8'($urandom)));
        n += 2;
      end else if (pick < 50) begin
        issue(form(OP_READ, 16'($urandom_range(ROM_BASE, 16'hffff)), 8'($urandom)));
        n++;
      end else if (pick < 58) begin
        issue(form(OP_WRITE, 16'($urandom_range(ROM_BASE, 16'hffff)), 8'($urandom)));
        issue(form(OP_READ, 16'($urandom_range(ROM_BASE, 16'hffff)), 8'($urandom)));
        n += 2;
      end else if (pick < 70) begin
        x = form($urandom_range(1) ? OP_WRITE : OP_READ,
                 16'($urandom_range(WRAM_END, ADDR_PAD1)), 8'($urandom));
        issue(x);
        n++;
      end else if (pick < 76) begin
        x = form($urandom_range(1) ? OP_WRITE : OP_READ,
                 16'($urandom_range(16'h4018, OPEN_END - 1)), 8'($urandom));
        issue(x);
        n++;
      end else if (pick < 82) begin
        issue(form(OP_LOAD, 16'($urandom), 8'($urandom), 1'($urandom),
                   18'($urandom_range(ROM_DEPTH - 1))));
        n++;
      end else begin
        x.op = op_t'($urandom_range(3));
        x.addr = 16'($urandom);
        x.data = 8'($urandom);
        x.ext = 8'($urandom);
        x.pad_port = 1'($urandom);
        x.rom_offset = 18'($urandom);
        issue(x);
        n++;
      end
    end
  endtask

  initial begin
    tracker = new();
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_READ;
    addr = '0;
    data = '0;
    ext_data = '0;
    pad_port = 1'b0;
    rom_offset = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MAPPER_KIND;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed pass at the reset mapping: fixed ROM, 32 KB, horizontal
    issue(form(OP_WRITE, 16'h0000, 8'ha5));
    issue(form(OP_WRITE, 16'h07ff, 8'h5a));
    issue(form(OP_READ, 16'h1800, 8'h00));
    issue(form(OP_READ, 16'h1fff, 8'hff));
    issue(form(OP_WRITE, WRAM_END, 8'hff));
    issue(form(OP_READ, PPU_END - 16'd1, 8'h00));
    issue(form(OP_WRITE, ADDR_DMA, 8'h02));
    issue(form(OP_WRITE, PPU_END, 8'h00));
    issue(form(OP_WRITE, APU_LAST, 8'h81));
    issue(form(OP_WRITE, ADDR_PAD1, 8'hff));
    issue(form(OP_READ, ADDR_APU_STATUS, 8'h00));
    issue(form(OP_READ, ADDR_DMA, 8'h00));
    issue(form(OP_WRITE, OPEN_END - 16'd1, 8'h3c));
    issue(form(OP_READ, 16'h4018, 8'h00));
    issue(form(OP_BUTTONS, 16'hffff, 8'hb5, 1'b0));
    issue(form(OP_BUTTONS, 16'h0000, 8'h4a, 1'b1));
    issue(form(OP_WRITE, ADDR_PAD0, 8'h01));
    issue(form(OP_READ, ADDR_PAD0, 8'h00));
    issue(form(OP_WRITE, ADDR_PAD0, 8'h00));
    issue(form(OP_READ, ADDR_PAD1, 8'h00));
    issue(form(OP_WRITE, CRAM_BASE, 8'h77));
    issue(form(OP_READ, CRAM_END - 16'd1, 8'h00));
    issue(form(OP_READ, CRAM_BASE, 8'h00));
    issue(form(OP_LOAD, 16'h0000, 8'hee, 1'b1, 18'h3ffff));
    issue(form(OP_READ, ROM_BASE, 8'h00));
    issue(form(OP_READ, 16'hffff, 8'h00));
    issue(form(OP_WRITE, ROM_BASE, 8'h13));
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      set_mapping(plan_kind[ph], plan_banks[ph], plan_vert[ph]);
      // hold the result side off so the pipeline backs up into the input
      if (ph == 1) out_hold = 96;
      calm = (ph == 3);
      random_phase(ITEMS_PER_PHASE);
      settle();
    end

    $display("covered %0d reads, %0d writes, %0d ROM loads, %0d button updates over %0d mappings",
             tracker.op_seen[OP_READ], tracker.op_seen[OP_WRITE], tracker.op_seen[OP_LOAD],
             tracker.op_seen[OP_BUTTONS], PHASES + 1);
    $display("%0d results matched, %0d failed, %0d never arrived",
             tracker.matched, tracker.mismatches, tracker.replies_due.size());
    if (tracker.mismatches == 0 && tracker.replies_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
